FILE: src/mjx_pkg.sv
// ----------------------------------------------------------------------------
// mjx_pkg
// Shared types, constants and character tables for the multipart JPEG part
// extractor.
// ----------------------------------------------------------------------------
package mjx_pkg;

	localparam int MAX_BOUNDARY = 32;
	localparam int WIN_DEPTH    = MAX_BOUNDARY + 2;

	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_COLON = 8'h3A;

	// Configuration register indexes
	localparam logic [2:0] REG_BND0 = 3'd0;
	localparam logic [2:0] REG_BND3 = 3'd3;
	localparam logic [2:0] REG_BLEN = 3'd4;

	typedef enum logic [2:0] {
		PH_HUNT,
		PH_AFTER,
		PH_HEAD,
		PH_COUNT,
		PH_POST,
		PH_DELIM
	} phase_t;

	typedef enum logic [1:0] {
		TY_EMPTY,
		TY_JPEG,
		TY_OTHER
	} part_type_t;

	typedef enum logic [1:0] {
		LN_START,
		LN_KEY,
		LN_SKIP,
		LN_VALUE
	} ln_mode_t;

	typedef struct packed {
		ln_mode_t   mode;
		logic [3:0] kpos;
		logic       key_type;
		logic       key_len;
		logic       key_gap;
		logic       val_seen;
		logic       val_gap;
		logic [3:0] vpos;
		logic       val_jpeg;
		logic       num_neg;
		logic       num_digit;
		logic       num_bad;
	} line_trk_t;

	// Line results handed from the header parser to the sequencer
	typedef struct packed {
		logic        hdr_end;
		logic        type_set;
		part_type_t  type_val;
		logic        len_set;
		logic        len_present;
		logic [30:0] rem;
	} hdr_upd_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       empty;
	} result_t;

	function automatic logic is_ws(input logic [7:0] c);
		return (c inside {[8'd9:8'd13], 8'd32});
	endfunction

	function automatic logic [7:0] to_lower(input logic [7:0] c);
		return (c inside {[8'h41:8'h5A]}) ? c + 8'd32 : c;
	endfunction

	function automatic logic [7:0] type_char(input logic [3:0] k);
		case (k)
			4'd0: return "c";
			4'd1: return "o";
			4'd2: return "n";
			4'd3: return "t";
			4'd4: return "e";
			4'd5: return "n";
			4'd6: return "t";
			4'd7: return "-";
			4'd8: return "t";
			4'd9: return "y";
			4'd10: return "p";
			4'd11: return "e";
			default: return 8'h00;
		endcase
	endfunction

	function automatic logic [7:0] len_char(input logic [3:0] k);
		case (k)
			4'd0: return "c";
			4'd1: return "o";
			4'd2: return "n";
			4'd3: return "t";
			4'd4: return "e";
			4'd5: return "n";
			4'd6: return "t";
			4'd7: return "-";
			4'd8: return "l";
			4'd9: return "e";
			4'd10: return "n";
			4'd11: return "g";
			4'd12: return "t";
			4'd13: return "h";
			default: return 8'h00;
		endcase
	endfunction

	function automatic logic [7:0] jpeg_char(input logic [3:0] k);
		case (k)
			4'd0: return "i";
			4'd1: return "m";
			4'd2: return "a";
			4'd3: return "g";
			4'd4: return "e";
			4'd5: return "/";
			4'd6: return "j";
			4'd7: return "p";
			4'd8: return "e";
			4'd9: return "g";
			default: return 8'h00;
		endcase
	endfunction

	function automatic logic [7:0] end_char(input logic [1:0] k);
		return k[0] ? CH_LF : CH_CR;
	endfunction

endpackage

FILE: src/multipart_jpeg_part_extractor_unit.sv
// ----------------------------------------------------------------------------
// multipart_jpeg_part_extractor_unit
// Byte-wide demultiplexer for multipart x-mixed-replace streams that emits
// the payload bytes of JPEG parts and of parts without a Content-Type.
// ----------------------------------------------------------------------------
// The block takes one stream byte per cycle and gives at most one payload
// byte per stream byte through an output register backed by a one-entry
// skid stage; input ready drops only when both are full.
// The 34-cell match window compares every cell's byte with its pattern byte
// in parallel, so boundary hunting, delimited payload end detection and
// header parsing all keep pace with the accepted stream bytes.
// Configuration writes are always taken; those to indexes 0 to 4 restart
// parsing from the boundary hunt; write them only while the stream is idle.
// A zero boundary length makes the block swallow all bytes; above 32 acts as 32.
module multipart_jpeg_part_extractor_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  stream_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  payload_byte,
	output logic        last_of_part,
	output logic        empty_part,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data
);
	import mjx_pkg::*;

	// Configuration registers
	logic [3:0][7:0][7:0] bnd_q;
	logic [5:0]           blen_q;
	logic [5:0]           eff_len;
	logic [5:0]           len2;
	logic                 cfg_hit;

	// Parse state
	phase_t     phase_q, phase_nx;
	logic [5:0] cnt_q, cnt_nx;
	part_type_t type_q, type_nx;
	logic       lp_q, lp_nx;
	logic [30:0] rem_q, rem_nx;

	// Window cells
	logic [7:0] cell_q   [WIN_DEPTH];
	logic [7:0] cell_din [WIN_DEPTH];
	logic [7:0] pat      [WIN_DEPTH];
	logic [WIN_DEPTH-1:0] hit, mlen, mdl;
	logic       step, in_acc, hunt_hit, delim_hit, eq1b0, had, jpeg, jpeg_nx;
	logic [7:0] ev;
	logic [5:0] n;
	logic [5:0] kidx;

	// Header parser link
	hdr_upd_t upd;
	logic     hdr_clr, hdr_feed;

	// Output stage
	result_t res, out_q, skid_q;
	logic    res_v, out_v_q, skid_v_q;

	assign cfg_ready = 1'b1;
	assign cfg_hit   = cfg_valid && (cfg_index <= REG_BLEN);
	assign eff_len   = (blen_q > 6'd32) ? 6'd32 : blen_q;
	assign len2      = eff_len + 6'd2;
	assign in_ready  = !skid_v_q;
	assign in_acc    = in_valid && in_ready;
	assign step      = in_acc && (eff_len != 6'd0);
	assign hdr_feed  = step && (phase_q == PH_HEAD);
	assign jpeg      = (type_q != TY_OTHER);
	assign n         = cnt_q + 6'd1;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bnd_q  <= '0;
			blen_q <= 6'd1;
		end else if (cfg_valid) begin
			if (cfg_index <= REG_BND3 && cfg_index >= REG_BND0) begin
				bnd_q[cfg_index[1:0]] <= cfg_data;
			end else if (cfg_index == REG_BLEN) begin
				blen_q <= cfg_data[5:0];
			end
		end
	end

	// Align the boundary to the cells: newest byte faces the marker's last byte,
	// followed by LF and CR for the delimiter check
	always_comb begin
		for (int j = 0; j < WIN_DEPTH; j++) begin
			kidx    = eff_len - 6'(j) - 6'd1;
			mlen[j] = (6'(j) < eff_len);
			mdl[j]  = (6'(j) < len2);
			if (6'(j) < eff_len) begin
				pat[j] = bnd_q[kidx[4:3]][kidx[2:0]];
			end else if (6'(j) == eff_len) begin
				pat[j] = CH_LF;
			end else if (6'(j) == eff_len + 6'd1) begin
				pat[j] = CH_CR;
			end else begin
				pat[j] = 8'h00;
			end
		end
	end

	// Chain of window cells
	assign cell_din[0] = stream_byte;
	for (genvar g = 0; g < WIN_DEPTH; g++) begin : g_cell
		if (g > 0) begin : g_link
			assign cell_din[g] = cell_q[g-1];
		end
		mjx_win_cell u_cell (
			.clk (clk),
			.en  (step),
			.din (cell_din[g]),
			.pat (pat[g]),
			.q   (cell_q[g]),
			.hit (hit[g])
		);
	end

	assign hunt_hit  = &(hit | ~mlen);
	assign delim_hit = &(hit | ~mdl);
	assign eq1b0     = (cell_q[0] == bnd_q[0][0]);
	assign had       = (cnt_q == len2);

	// Pick the oldest window byte, which leaves the delay line
	always_comb begin
		ev = 8'h00;
		for (int j = 0; j < WIN_DEPTH; j++) begin
			if (6'(j) == eff_len + 6'd1) begin
				ev = cell_q[j];
			end
		end
	end

	mjx_hdr_parser u_hdr (
		.clk    (clk),
		.arst_n (arst_n),
		.clr    (hdr_clr),
		.feed   (hdr_feed),
		.din    (stream_byte),
		.upd    (upd)
	);

	// Next parse state and result
	always_comb begin
		phase_nx = phase_q;
		cnt_nx   = cnt_q;
		type_nx  = type_q;
		lp_nx    = lp_q;
		rem_nx   = rem_q;
		hdr_clr  = 1'b0;
		res_v    = 1'b0;
		res      = '0;
		jpeg_nx  = jpeg;
		if (cfg_hit) begin
			phase_nx = PH_HUNT;
			cnt_nx   = '0;
			type_nx  = TY_EMPTY;
			lp_nx    = 1'b0;
			rem_nx   = '0;
			hdr_clr  = 1'b1;
		end else if (step) begin
			case (phase_q)
				PH_HUNT: begin
					if (n == eff_len && hunt_hit) begin
						phase_nx = PH_AFTER;
						cnt_nx   = '0;
					end else begin
						cnt_nx = (n >= eff_len) ? eff_len - 6'd1 : n;
					end
				end
				PH_AFTER, PH_POST: begin
					if (n < 6'd2) begin
						cnt_nx = n;
					end else if (phase_q == PH_AFTER && cell_q[0] == CH_DASH &&
						stream_byte == CH_DASH) begin
						phase_nx = PH_HUNT;
						cnt_nx   = '0;
					end else if (cell_q[0] == CH_CR && stream_byte == CH_LF) begin
						cnt_nx = '0;
						if (phase_q == PH_AFTER) begin
							phase_nx = PH_HEAD;
							type_nx  = TY_EMPTY;
							lp_nx    = 1'b0;
							rem_nx   = '0;
							hdr_clr  = 1'b1;
						end else begin
							phase_nx = PH_HUNT;
						end
					end else if (eff_len == 6'd1 && eq1b0) begin
						// Marker matches the older byte; the newer one stays
						phase_nx = PH_AFTER;
						cnt_nx   = 6'd1;
					end else if (eff_len <= 6'd2 && hunt_hit) begin
						phase_nx = PH_AFTER;
						cnt_nx   = '0;
					end else begin
						phase_nx = PH_HUNT;
						cnt_nx   = (eff_len > 6'd2) ? 6'd2 : eff_len - 6'd1;
					end
				end
				PH_HEAD: begin
					if (upd.type_set) begin
						type_nx = upd.type_val;
					end
					if (upd.len_set) begin
						lp_nx  = upd.len_present;
						rem_nx = upd.rem;
					end
					jpeg_nx = (type_nx != TY_OTHER);
					if (upd.hdr_end) begin
						cnt_nx = '0;
						if (!lp_nx) begin
							phase_nx = PH_DELIM;
						end else if (rem_nx != '0) begin
							phase_nx = PH_COUNT;
						end else begin
							phase_nx  = PH_POST;
							res_v     = jpeg_nx;
							res.last  = 1'b1;
							res.empty = 1'b1;
						end
					end
				end
				PH_COUNT: begin
					rem_nx   = (rem_q != '0) ? rem_q - 31'd1 : '0;
					res_v    = jpeg;
					res.data = stream_byte;
					res.last = (rem_q <= 31'd1);
					if (rem_q <= 31'd1) begin
						phase_nx = PH_POST;
						cnt_nx   = '0;
					end
				end
				PH_DELIM: begin
					cnt_nx = had ? cnt_q : n;
					if (cnt_nx == len2 && delim_hit) begin
						phase_nx  = PH_AFTER;
						cnt_nx    = '0;
						res_v     = jpeg;
						res.data  = had ? ev : 8'h00;
						res.last  = 1'b1;
						res.empty = !had;
					end else begin
						res_v    = had && jpeg;
						res.data = ev;
					end
				end
				default: begin
					phase_nx = PH_HUNT;
				end
			endcase
		end
	end

	// Hold parse state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			cnt_q   <= '0;
			type_q  <= TY_EMPTY;
			lp_q    <= 1'b0;
			rem_q   <= '0;
		end else begin
			phase_q <= phase_nx;
			cnt_q   <= cnt_nx;
			type_q  <= type_nx;
			lp_q    <= lp_nx;
			rem_q   <= rem_nx;
		end
	end

	// Output register with skid stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (out_ready || !out_v_q) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= res_v;
			end
		end else if (res_v) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready || !out_v_q) begin
			out_q <= skid_v_q ? skid_q : res;
		end else if (res_v) begin
			skid_q <= res;
		end
	end

	assign out_valid    = out_v_q;
	assign payload_byte = out_q.data;
	assign last_of_part = out_q.last;
	assign empty_part   = out_q.empty;

	// The skid stage fills only behind a waiting result
	assert property (@(posedge clk) disable iff (!arst_n) skid_v_q |-> out_v_q)
		else $error("skid entry without output entry");

	// A resting hunt keeps fewer bytes than the marker
	assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_HUNT && eff_len != 6'd0) |-> (cnt_q < eff_len))
		else $error("hunt window overfull");

	// The pair checks after a boundary or a counted payload hold at most one byte
	assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_AFTER || phase_q == PH_POST) |-> (cnt_q < 6'd2))
		else $error("pair window overfull");

	// An empty marker closes its part and carries a zero byte
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && out_q.empty) |-> (out_q.last && out_q.data == 8'h00))
		else $error("malformed empty marker");

	// The window never holds more than the marker plus CRLF
	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= len2 || eff_len == 6'd0)
		else $error("window count out of range");

endmodule

FILE: src/mjx_win_cell.sv
// ----------------------------------------------------------------------------
// mjx_win_cell
// One byte cell of the match window: holds a byte, takes its neighbor's byte
// on each shift and compares the incoming byte with its pattern byte.
// ----------------------------------------------------------------------------
module mjx_win_cell (
	input  logic       clk,
	input  logic       en,
	input  logic [7:0] din,
	input  logic [7:0] pat,
	output logic [7:0] q,
	output logic       hit
);

	// Compare the byte that this cell holds after the shift
	assign hit = (din == pat);

	// Shift in the neighbor's byte
	always_ff @(posedge clk) begin
		if (en) begin
			q <= din;
		end
	end

endmodule

FILE: src/mjx_hdr_parser.sv
// ----------------------------------------------------------------------------
// mjx_hdr_parser
// Header block parser: splits lines on LF, matches keys without regard to
// case, decodes Content-Length and Content-Type, and spots CRLFCRLF.
// ----------------------------------------------------------------------------
module mjx_hdr_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              clr,
	input  logic              feed,
	input  logic [7:0]        din,
	output mjx_pkg::hdr_upd_t upd
);
	import mjx_pkg::*;

	line_trk_t   trk_q, trk_nx;
	logic [31:0] acc_q, acc_nx;
	logic [2:0]  det_q, det_nx;
	logic [7:0]  lc;
	logic [35:0] prod;
	logic        first;

	assign lc   = to_lower(din);
	assign prod = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1) + {32'b0, din[3:0]};

	// Advance the line tracker by one byte
	always_comb begin
		trk_nx = trk_q;
		acc_nx = acc_q;
		det_nx = det_q;
		upd    = '0;
		first  = 1'b0;
		if (clr) begin
			trk_nx = '0;
			acc_nx = '0;
			det_nx = '0;
		end else if (feed) begin
			// Track progress through CRLFCRLF
			if (din == end_char(det_q[1:0])) begin
				det_nx = det_q + 3'd1;
			end else begin
				det_nx = (din == CH_CR) ? 3'd1 : 3'd0;
			end
			if (det_nx == 3'd4) begin
				upd.hdr_end = 1'b1;
				det_nx      = '0;
			end

			if (din == CH_LF) begin
				// Close the line and report its key
				if (trk_q.mode == LN_VALUE) begin
					if (trk_q.key_type && trk_q.kpos == 4'd12) begin
						upd.type_set = 1'b1;
						if (!trk_q.val_seen) begin
							upd.type_val = TY_EMPTY;
						end else if (trk_q.val_jpeg && trk_q.vpos == 4'd10) begin
							upd.type_val = TY_JPEG;
						end else begin
							upd.type_val = TY_OTHER;
						end
					end else if (trk_q.key_len && trk_q.kpos == 4'd14) begin
						upd.len_set     = 1'b1;
						upd.len_present = 1'b1;
						if (!trk_q.num_bad && trk_q.num_digit) begin
							if (trk_q.num_neg) begin
								if (acc_q != 32'd0 && acc_q <= 32'h8000_0000) begin
									upd.len_present = 1'b0;
								end
							end else if (acc_q <= 32'h7FFF_FFFF) begin
								upd.rem = acc_q[30:0];
							end
						end
					end
				end
				trk_nx = '0;
				acc_nx = '0;
			end else begin
				case (trk_q.mode)
					LN_START: begin
						if (din == CH_COLON) begin
							trk_nx.mode = LN_SKIP;
						end else if (!is_ws(din)) begin
							trk_nx.mode     = LN_KEY;
							trk_nx.key_gap  = 1'b0;
							trk_nx.key_type = (lc == type_char(4'd0));
							trk_nx.key_len  = (lc == len_char(4'd0));
							trk_nx.kpos     = 4'd1;
						end
					end
					LN_KEY: begin
						if (din == CH_COLON) begin
							trk_nx.mode      = LN_VALUE;
							trk_nx.val_seen  = 1'b0;
							trk_nx.val_gap   = 1'b0;
							trk_nx.vpos      = '0;
							trk_nx.val_jpeg  = 1'b1;
							trk_nx.num_neg   = 1'b0;
							trk_nx.num_digit = 1'b0;
							trk_nx.num_bad   = 1'b0;
							acc_nx           = '0;
						end else if (is_ws(din)) begin
							trk_nx.key_gap = 1'b1;
						end else begin
							trk_nx.key_type = trk_q.key_type && !trk_q.key_gap &&
								trk_q.kpos < 4'd12 && lc == type_char(trk_q.kpos);
							trk_nx.key_len = trk_q.key_len && !trk_q.key_gap &&
								trk_q.kpos < 4'd14 && lc == len_char(trk_q.kpos);
							if (trk_q.kpos != 4'd15) begin
								trk_nx.kpos = trk_q.kpos + 4'd1;
							end
						end
					end
					LN_VALUE: begin
						if (is_ws(din)) begin
							if (trk_q.val_seen) begin
								trk_nx.val_gap = 1'b1;
							end
						end else begin
							first           = !trk_q.val_seen;
							trk_nx.val_seen = 1'b1;
							trk_nx.num_bad  = trk_q.num_bad || trk_q.val_gap;
							trk_nx.val_jpeg = trk_q.val_jpeg && !trk_q.val_gap &&
								trk_q.vpos < 4'd10 && lc == jpeg_char(trk_q.vpos);
							if (trk_q.vpos < 4'd11) begin
								trk_nx.vpos = trk_q.vpos + 4'd1;
							end
							if (first && (din == CH_PLUS || din == CH_DASH)) begin
								trk_nx.num_neg = (din == CH_DASH);
							end else if (din inside {["0":"9"]}) begin
								acc_nx = (prod > 36'h0_8000_0000) ? 32'h8000_0001 :
									prod[31:0];
								trk_nx.num_digit = 1'b1;
							end else begin
								trk_nx.num_bad = 1'b1;
							end
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	// Hold tracker state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trk_q <= '0;
			acc_q <= '0;
			det_q <= '0;
		end else begin
			trk_q <= trk_nx;
			acc_q <= acc_nx;
			det_q <= det_nx;
		end
	end

endmodule
